/* rtl/r2fft_pkg.sv */
// ----------------------------------------------------------------------------
// r2fft_pkg: shared types and constants for the radix-2 FFT
// Twiddle table, saturation, controller states and the controller/datapath command struct.
// ----------------------------------------------------------------------------
package r2fft_pkg;

    localparam int unsigned DataW = 24;
    localparam int unsigned InW   = 16;
    localparam int unsigned TwW   = 17;
    localparam int unsigned MaxLg = 6;
    localparam int unsigned AddrW = 6;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_BF_RD,
        ST_BF_MUL,
        ST_BF_WR,
        ST_DIV,
        ST_OUT
    } t_state;

    // Command from controller to datapath
    typedef struct packed {
        logic             load_we;
        logic [AddrW-1:0] load_addr;
        logic [AddrW-1:0] addr_a;
        logic [AddrW-1:0] addr_b;
        logic             zero_a;
        logic             zero_b;
        logic [4:0]       tw_idx;
        logic             do_mul;
        logic             do_wr;
        logic             do_div;
        logic [2:0]       lg;
        logic             rd_out;
    } t_cmd;

    // cos(pi*k/32) * 32768, rounded, k = 0..16
    function automatic logic signed [TwW-1:0] quarter_cos(input logic [4:0] k);
        logic signed [TwW-1:0] v;
        case (k)
            5'd0:  v = 17'sd32768;
            5'd1:  v = 17'sd32610;
            5'd2:  v = 17'sd32138;
            5'd3:  v = 17'sd31357;
            5'd4:  v = 17'sd30274;
            5'd5:  v = 17'sd28899;
            5'd6:  v = 17'sd27246;
            5'd7:  v = 17'sd25330;
            5'd8:  v = 17'sd23170;
            5'd9:  v = 17'sd20788;
            5'd10: v = 17'sd18205;
            5'd11: v = 17'sd15447;
            5'd12: v = 17'sd12540;
            5'd13: v = 17'sd9512;
            5'd14: v = 17'sd6393;
            5'd15: v = 17'sd3212;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

    // Saturate a wide sum to the data width
    function automatic logic signed [DataW-1:0] sat24(input logic signed [DataW+1:0] x);
        logic signed [DataW-1:0] v;
        if (x > 26'sd8388607) begin
            v = 24'sd8388607;
        end else if (x < -26'sd8388608) begin
            v = -24'sd8388608;
        end else begin
            v = x[DataW-1:0];
        end
        return v;
    endfunction

endpackage

/* rtl/r2fft_datapath.sv */
// ----------------------------------------------------------------------------
// r2fft_datapath: sample memory and one butterfly unit
// Holds the working set, runs butterflies, inverse scaling and bin reads.
// ----------------------------------------------------------------------------
module r2fft_datapath
    import r2fft_pkg::*;
(
    input  logic                    i_clk,
    input  t_cmd                    i_cmd,
    input  logic                    i_inverse,
    input  logic signed [InW-1:0]   i_re,
    input  logic signed [InW-1:0]   i_im,
    output logic signed [DataW-1:0] o_re,
    output logic signed [DataW-1:0] o_im
);

    logic signed [DataW-1:0] r_mem_re [64];
    logic signed [DataW-1:0] r_mem_im [64];
    logic signed [DataW-1:0] r_ar, r_ai, r_br, r_bi;
    logic signed [DataW-1:0] r_ur, r_ui;
    logic signed [DataW:0]   r_vr, r_vi;
    logic signed [TwW-1:0]   w_c, w_s;
    logic signed [41:0]      w_pr, w_pi;
    logic signed [DataW:0]   w_vr, w_vi;
    logic signed [DataW:0]   w_dr, w_di;
    logic [4:0]              w_t;

    // Twiddle lookup; forward negates sine
    always_comb begin
        w_t = i_cmd.tw_idx;
        if (w_t <= 5'd16) begin
            w_c = quarter_cos(w_t);
            w_s = quarter_cos(5'd16 - w_t);
        end else begin
            w_c = -quarter_cos(5'd0 - w_t);
            w_s = quarter_cos(w_t - 5'd16);
        end
        if (!i_inverse) begin
            w_s = -w_s;
        end
    end

    // Complex product with rounding; the product can exceed the data width
    always_comb begin
        w_pr = 42'(r_br) * 42'(w_c) - 42'(r_bi) * 42'(w_s) + 42'sd16384;
        w_pi = 42'(r_br) * 42'(w_s) + 42'(r_bi) * 42'(w_c) + 42'sd16384;
        w_vr = w_pr[DataW+15:15];
        w_vi = w_pi[DataW+15:15];
    end

    // Rounding shift for inverse scaling of the word at port a
    always_comb begin
        w_dr = (25'(r_ar) + (25'sd1 <<< (i_cmd.lg - 3'd1))) >>> i_cmd.lg;
        w_di = (25'(r_ai) + (25'sd1 <<< (i_cmd.lg - 3'd1))) >>> i_cmd.lg;
    end

    // Memory ports and butterfly registers; padding slots read as zero
    always_ff @(posedge i_clk) begin
        r_ar <= i_cmd.zero_a ? '0 : r_mem_re[i_cmd.addr_a];
        r_ai <= i_cmd.zero_a ? '0 : r_mem_im[i_cmd.addr_a];
        r_br <= i_cmd.zero_b ? '0 : r_mem_re[i_cmd.addr_b];
        r_bi <= i_cmd.zero_b ? '0 : r_mem_im[i_cmd.addr_b];
        if (i_cmd.do_mul) begin
            r_ur <= r_ar;
            r_ui <= r_ai;
            r_vr <= w_vr;
            r_vi <= w_vi;
        end
        if (i_cmd.load_we) begin
            r_mem_re[i_cmd.load_addr] <= DataW'(i_re);
            r_mem_im[i_cmd.load_addr] <= DataW'(i_im);
        end else if (i_cmd.do_wr) begin
            r_mem_re[i_cmd.addr_a] <= sat24(26'(r_ur) + 26'(r_vr));
            r_mem_im[i_cmd.addr_a] <= sat24(26'(r_ui) + 26'(r_vi));
            r_mem_re[i_cmd.addr_b] <= sat24(26'(r_ur) - 26'(r_vr));
            r_mem_im[i_cmd.addr_b] <= sat24(26'(r_ui) - 26'(r_vi));
        end else if (i_cmd.do_div) begin
            r_mem_re[i_cmd.addr_b] <= w_dr[DataW-1:0];
            r_mem_im[i_cmd.addr_b] <= w_di[DataW-1:0];
        end
    end

    assign o_re = r_ar;
    assign o_im = r_ai;

endmodule

/* rtl/r2fft_ctrl.sv */
// ----------------------------------------------------------------------------
// r2fft_ctrl: load, butterfly and unload sequencer
// Counts samples, schedules stages and drives the output register.
// ----------------------------------------------------------------------------
module r2fft_ctrl
    import r2fft_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_inverse,
    input  logic       i_valid,
    input  logic       i_last,
    output logic       o_in_stall,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output logic [5:0] o_index,
    output logic       o_bin_last,
    output logic       o_trunc,
    output logic       o_cap,
    output t_cmd       o_cmd
);

    t_state     r_state, n_state;
    logic [6:0] r_cnt;
    logic       r_ovf;
    logic       r_trunc;
    logic [2:0] r_lg, r_stage;
    logic [6:0] r_j;
    logic [6:0] r_n;
    logic       w_acc, w_last_bf, w_free;
    logic [2:0] w_lg;
    logic [5:0] w_lo, w_hi, w_k;
    logic [6:0] w_half;
    logic [5:0] w_lo_p, w_hi_p, w_out_p;

    // Reverse the low lg bits of an address
    function automatic logic [5:0] bit_rev(input logic [5:0] x, input logic [2:0] lg);
        logic [5:0] v;
        v = '0;
        for (int b = 0; b < 6; b++) begin
            if (b < int'(lg)) begin
                v[lg - 3'd1 - 3'(b)] = x[b];
            end
        end
        return v;
    endfunction

    // Output register and input handshakes
    assign w_free = !o_out_valid || !i_out_stall;
    assign w_acc  = i_valid && !o_in_stall;

    // Size needed for the held count, counting the incoming sample
    always_comb begin
        logic [6:0] c;
        c = (r_cnt < 7'd64) ? r_cnt + 7'd1 : r_cnt;
        w_lg = 3'd0;
        for (int b = 0; b < 7; b++) begin
            if ((7'd1 << w_lg) < c) begin
                w_lg = w_lg + 3'd1;
            end
        end
    end

    // Butterfly addresses: stage s (half = 2^s), counter j; working slot p
    // lives at memory address bit_rev(p), so samples load in natural order
    always_comb begin
        w_half = 7'd1 << r_stage;
        w_k    = 6'(r_j) & 6'(w_half - 7'd1);
        w_lo   = 6'((r_j - 7'(w_k)) << 1) | w_k;
        w_hi   = w_lo | 6'(w_half);
        w_last_bf = (r_j == (r_n >> 1) - 7'd1);
        w_lo_p = bit_rev(w_lo, r_lg);
        w_hi_p = bit_rev(w_hi, r_lg);
        // Hold the read address of the waiting bin while the output is full
        w_out_p = w_free ? bit_rev(6'(r_j), r_lg) : bit_rev(6'(r_j - 7'd1), r_lg);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD:   if (w_acc && i_last) begin
                n_state = (w_lg == 3'd0) ? ST_OUT : ST_BF_RD;
            end
            ST_BF_RD:  n_state = ST_BF_MUL;
            ST_BF_MUL: n_state = ST_BF_WR;
            ST_BF_WR:  if (w_last_bf && r_stage == r_lg - 3'd1) begin
                n_state = (i_inverse) ? ST_DIV : ST_OUT;
            end else begin
                n_state = ST_BF_RD;
            end
            ST_DIV:    if (r_j == r_n) begin
                n_state = ST_OUT;
            end
            ST_OUT:    if (w_free && r_j == r_n) begin
                n_state = ST_LOAD;
            end
            default:   n_state = ST_LOAD;
        endcase
    end

    // Outputs to datapath; first stage reads slots past the held count as zero
    always_comb begin
        o_in_stall    = (r_state != ST_LOAD);
        o_cmd         = '0;
        o_cmd.lg      = r_lg;
        o_cmd.load_we = w_acc && (r_cnt < 7'd64);
        o_cmd.load_addr = r_cnt[5:0];
        o_cmd.tw_idx  = 5'(w_k << (3'd5 - r_stage));
        o_cap         = 1'b0;
        case (r_state)
            ST_BF_RD, ST_BF_MUL, ST_BF_WR: begin
                o_cmd.addr_a = w_lo_p;
                o_cmd.addr_b = w_hi_p;
                o_cmd.zero_a = (r_stage == 3'd0) && ({1'b0, w_lo_p} >= r_cnt);
                o_cmd.zero_b = (r_stage == 3'd0) && ({1'b0, w_hi_p} >= r_cnt);
                o_cmd.do_mul = (r_state == ST_BF_MUL);
                o_cmd.do_wr  = (r_state == ST_BF_WR);
            end
            ST_DIV: begin
                o_cmd.addr_a = r_j[5:0];
                o_cmd.addr_b = 6'(r_j - 7'd1);
                o_cmd.do_div = (r_j != 7'd0);
            end
            ST_OUT: begin
                o_cmd.addr_a = w_out_p;
                o_cap        = w_free;
            end
            default: ;
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_trunc     <= 1'b0;
            r_lg        <= '0;
            r_stage     <= '0;
            r_j         <= '0;
            r_n         <= '0;
            o_out_valid <= 1'b0;
            o_index     <= '0;
            o_bin_last  <= 1'b0;
            o_trunc     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                ST_LOAD: if (w_acc) begin
                    if (r_cnt < 7'd64) begin
                        r_cnt <= r_cnt + 7'd1;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                    if (i_last) begin
                        r_lg    <= w_lg;
                        r_n     <= 7'd1 << w_lg;
                        r_stage <= '0;
                        r_j     <= '0;
                        r_trunc <= r_ovf || (r_cnt == 7'd64);
                    end
                end
                ST_BF_WR: begin
                    if (w_last_bf) begin
                        r_j     <= '0;
                        r_stage <= r_stage + 3'd1;
                    end else begin
                        r_j <= r_j + 7'd1;
                    end
                end
                ST_DIV: r_j <= (r_j == r_n) ? 7'd0 : r_j + 7'd1;
                ST_OUT: if (w_free) begin
                    if (r_j == r_n) begin
                        r_cnt <= '0;
                        r_ovf <= 1'b0;
                        r_j   <= '0;
                    end else begin
                        r_j <= r_j + 7'd1;
                    end
                    if (r_j != 7'd0) begin
                        o_out_valid <= 1'b1;
                        o_index     <= 6'(r_j - 7'd1);
                        o_bin_last  <= (r_j == r_n);
                        o_trunc     <= r_trunc;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* rtl/radix2_fft.sv */
// ----------------------------------------------------------------------------
// radix2_fft: radix-2 decimation-in-time FFT, up to 64 points
// Loads complex samples, runs butterflies with one shared unit, emits bins.
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  sample    in         valid / stall    sample_re, sample_im, sample_last
//  bin       out        valid / stall    bin_re, bin_im, bin_index, bin_last,
//                                        truncated
//  config    in         valid / ready    inverse_mode
//
//  Load accepts one sample per cycle. A transform of n = 2^lg points runs
//  (n/2)*lg butterflies in turn through one memory and one complex
//  multiplier (read, multiply, write states); inverse adds a scaling pass before unload.
//  Reset is synchronous, active low; the sample memory is not cleared, and
//  padding slots are read as zero in the first stage.
//  Input stall is high outside loading; output stall freezes the unload.
// ----------------------------------------------------------------------------
module radix2_fft
    import r2fft_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic                    i_cfg_inverse_mode,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [InW-1:0]   i_sample_re,
    input  logic signed [InW-1:0]   i_sample_im,
    input  logic                    i_sample_last,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [DataW-1:0] o_bin_re,
    output logic signed [DataW-1:0] o_bin_im,
    output logic [5:0]              o_bin_index,
    output logic                    o_bin_last,
    output logic                    o_truncated
);

    logic                    r_inverse;
    t_cmd                    w_cmd;
    logic                    w_cap;
    logic signed [DataW-1:0] w_re, w_im;

    assign o_cfg_ready = 1'b1;

    // Hold the mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inverse <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_inverse <= i_cfg_inverse_mode;
        end
    end

    r2fft_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_inverse   (r_inverse),
        .i_valid     (i_valid),
        .i_last      (i_sample_last),
        .o_in_stall  (o_stall),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .o_index     (o_bin_index),
        .o_bin_last  (o_bin_last),
        .o_trunc     (o_truncated),
        .o_cap       (w_cap),
        .o_cmd       (w_cmd)
    );

    r2fft_datapath u_dp (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_inverse (r_inverse),
        .i_re      (i_sample_re),
        .i_im      (i_sample_im),
        .o_re      (w_re),
        .o_im      (w_im)
    );

    // Capture bin into the output register
    always_ff @(posedge i_clk) begin
        if (w_cap) begin
            o_bin_re <= w_re;
            o_bin_im <= w_im;
        end
    end

endmodule
